FILE: rtl/chd_pkg.sv
`default_nettype none

package chd_pkg;

   // Characters that steer the decoder.
   localparam logic [7:0] CHAR_PIPE    = 8'h7C;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Decoder modes.
   typedef enum logic [2:0] {
      MODE_OUTSIDE    = 3'd0,
      MODE_FIRST      = 3'd1,
      MODE_SECOND     = 3'd2,
      MODE_AFTER      = 3'd3,
      MODE_DISCARD    = 3'd4,
      MODE_SECOND_BAD = 3'd5
   } mode_type;

   // Error codes reported on the result channel.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_SPACE     = 2'd1,
      ERR_BAD_DIGIT = 2'd2,
      ERR_CUT_PAIR  = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      err_type    error_code;
      logic       last;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: rtl/chd_req_if.sv
`default_nettype none

interface chd_req_if;
   logic                     valid;
   logic                     ready;
   chd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/chd_rsp_if.sv
`default_nettype none

interface chd_rsp_if;
   logic                     valid;
   logic                     ready;
   chd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/content_hex_escape_decoder.sv
`default_nettype none

// Content string hex escape decoder.
// The req_ch channel takes one character of a rule content string per item,
// with end_of_string set on the last character. Outside pipes a character
// comes out unchanged; between pipes each pair of hex digits comes out as one
// byte. The rsp_ch channel carries zero or one result item per character: a
// byte, an error code, or the end-of-string mark (last), or a mix of these.
// Characters that give no result (pipes, separators, first digits, discarded
// characters) are absorbed without any item on rsp_ch.
// From acceptance to rsp_ch.valid, the character waits in the input register,
// and the decode logic loads the result register when the input register
// moves on. One item can be accepted in every cycle while the receiver does
// not stall; the rate is set by the single decode stage and its mode
// register, which is updated once per character.
// When the receiver stalls, the result register holds its item and the input
// register keeps the next character that gives a result; req_ch.ready then
// drops until rsp_ch.ready returns.
// A synchronous reset empties both registers and returns the decoder to the
// outside-pipes mode with a cleared high nibble.
module content_hex_escape_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   chd_req_if.sink    req_ch,
   chd_rsp_if.source  rsp_ch
);

   // Input register.
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   chd_pkg::req_payload_type s1_data_ff;

   // Decoder state.
   chd_pkg::mode_type mode_ff;
   logic [3:0]        high_nibble_ff;

   // Result register.
   logic                     out_valid_ff;
   logic                     out_valid_in;
   chd_pkg::rsp_payload_type out_data_ff;

   // Decode results for the character in the input register.
   logic              is_hex;
   logic [3:0]        nibble;
   logic              has_byte;
   logic [7:0]        byte_val;
   chd_pkg::err_type  err;
   chd_pkg::mode_type next_mode;
   logic [3:0]        high_nibble_in;
   logic              produce;
   logic              s1_go;
   logic              req_fire;

   // Hex digit recognition in either case.
   always_comb begin
      logic [7:0] c;
      c = s1_data_ff.in_char;
      is_hex = 1'b1;
      nibble = 4'd0;
      if (c >= chd_pkg::CHAR_ZERO && c <= chd_pkg::CHAR_NINE) begin
         nibble = 4'(c - chd_pkg::CHAR_ZERO);
      end else if (c >= chd_pkg::CHAR_UPPER_A && c <= chd_pkg::CHAR_UPPER_F) begin
         nibble = 4'(c - chd_pkg::CHAR_UPPER_A + 8'd10);
      end else if (c >= chd_pkg::CHAR_LOWER_A && c <= chd_pkg::CHAR_LOWER_F) begin
         nibble = 4'(c - chd_pkg::CHAR_LOWER_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   // Mode transitions and result for one character.
   always_comb begin
      logic       eos;
      logic       is_space;
      logic       is_pipe;
      eos            = s1_data_ff.end_of_string;
      is_space       = (s1_data_ff.in_char == chd_pkg::CHAR_SPACE);
      is_pipe        = (s1_data_ff.in_char == chd_pkg::CHAR_PIPE);
      has_byte       = 1'b0;
      byte_val       = 8'd0;
      err            = chd_pkg::ERR_NONE;
      next_mode      = mode_ff;
      high_nibble_in = high_nibble_ff;
      unique case (mode_ff)
         chd_pkg::MODE_FIRST: begin
            if (is_space) begin
               err = chd_pkg::ERR_SPACE;
            end else if (is_hex) begin
               high_nibble_in = nibble;
               next_mode      = chd_pkg::MODE_SECOND;
               if (eos) err = chd_pkg::ERR_CUT_PAIR;
            end else begin
               next_mode = chd_pkg::MODE_SECOND_BAD;
               if (eos) err = chd_pkg::ERR_BAD_DIGIT;
            end
         end
         chd_pkg::MODE_SECOND: begin
            if (is_space) begin
               err = chd_pkg::ERR_SPACE;
            end else if (is_hex) begin
               byte_val  = {high_nibble_ff, nibble};
               has_byte  = 1'b1;
               next_mode = chd_pkg::MODE_AFTER;
            end else begin
               err = chd_pkg::ERR_BAD_DIGIT;
            end
         end
         chd_pkg::MODE_SECOND_BAD: begin
            err = is_space ? chd_pkg::ERR_SPACE : chd_pkg::ERR_BAD_DIGIT;
         end
         chd_pkg::MODE_AFTER: begin
            if (is_pipe) begin
               next_mode = chd_pkg::MODE_OUTSIDE;
            end else begin
               next_mode = chd_pkg::MODE_FIRST;
               if (eos) err = chd_pkg::ERR_CUT_PAIR;
            end
         end
         chd_pkg::MODE_DISCARD: begin
         end
         default: begin
            // Outside pipes, and the unused mode codes.
            if (is_pipe) begin
               next_mode = chd_pkg::MODE_FIRST;
               if (eos) err = chd_pkg::ERR_CUT_PAIR;
            end else begin
               byte_val  = s1_data_ff.in_char;
               has_byte  = 1'b1;
               next_mode = chd_pkg::MODE_OUTSIDE;
            end
         end
      endcase
      if (err != chd_pkg::ERR_NONE) next_mode = chd_pkg::MODE_DISCARD;
      produce = has_byte || (err != chd_pkg::ERR_NONE) || eos;
   end

   // Handshake: the input register moves on when its item gives no result
   // or the result register is free or being emptied.
   assign s1_go        = s1_valid_ff && (!produce || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign out_valid_in = (s1_go && produce) || (out_valid_ff && !rsp_ch.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         mode_ff        <= chd_pkg::MODE_OUTSIDE;
         high_nibble_ff <= 4'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_go) begin
            if (s1_data_ff.end_of_string) begin
               mode_ff        <= chd_pkg::MODE_OUTSIDE;
               high_nibble_ff <= 4'd0;
            end else begin
               mode_ff        <= next_mode;
               high_nibble_ff <= high_nibble_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_ch.payload;
      end
      if (s1_go && produce) begin
         out_data_ff.out_byte   <= byte_val;
         out_data_ff.has_byte   <= has_byte;
         out_data_ff.error_code <= err;
         out_data_ff.last       <= s1_data_ff.end_of_string;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

endmodule

`default_nettype wire

FILE: rtl/chd_checker.sv
`default_nettype none

module chd_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire chd_pkg::rsp_payload_type rsp_payload
);

   // A stalled result holds its place and its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed or vanished");

   // Both registers are empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // Input is only held back while a result waits on the receiver.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // A result carries a byte or an error, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.has_byte |-> rsp_payload.error_code == chd_pkg::ERR_NONE)
      else $error("result carries both a byte and an error");

endmodule

bind content_hex_escape_decoder chd_checker u_chd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire
